/* src/ufp_pkg.sv */
// shared types, constants and helpers of the telemetry frame parser
`default_nettype none
package ufp_pkg;

   localparam int FRAME_BYTES = 64;
   localparam int POS_W       = $clog2(FRAME_BYTES);
   localparam int ACC_W       = 28;
   localparam int ERR_W       = 8;
   localparam int IDX_W       = 4;
   localparam int KIND_W      = 2;
   localparam int BAT_W       = 2;
   localparam int HDR_W       = 32;

   localparam logic [HDR_W-1:0] HEADER_RESET = 32'h4144_3030;

   // frame byte positions
   localparam logic [POS_W-1:0] POS_HDR_LAST    = POS_W'(3);
   localparam logic [POS_W-1:0] POS_HDR_END     = POS_W'(4);
   localparam logic [POS_W-1:0] POS_SHORT_END   = POS_W'(48);
   localparam logic [POS_W-1:0] POS_FIELDS_LAST = POS_W'(55);
   localparam logic [POS_W-1:0] POS_ERR         = POS_W'(56);
   localparam logic [POS_W-1:0] POS_ERR_LAST    = POS_W'(57);
   localparam logic [POS_W-1:0] POS_SOLAR       = POS_W'(58);
   localparam logic [POS_W-1:0] POS_INV         = POS_W'(59);
   localparam logic [POS_W-1:0] POS_BAT         = POS_W'(60);
   localparam logic [POS_W-1:0] POS_LOAD        = POS_W'(61);
   localparam logic [POS_W-1:0] POS_LOAD_LAST   = POS_W'(62);
   localparam logic [POS_W-1:0] POS_CHG         = POS_W'(FRAME_BYTES - 1);

   // ascii codes
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_1     = 8'h31;
   localparam logic [7:0] CH_9     = 8'h39;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_FIELD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STATUS = 2'd1;
   localparam logic [KIND_W-1:0] KIND_HDR    = 2'd2;

   // battery codes
   localparam logic [BAT_W-1:0] BAT_NORMAL   = 2'd0;
   localparam logic [BAT_W-1:0] BAT_LOW_TRIP = 2'd1;
   localparam logic [BAT_W-1:0] BAT_LOW      = 2'd2;

   // fields already given in hundredths
   localparam logic [IDX_W-1:0] FLD_A = 4'd2;
   localparam logic [IDX_W-1:0] FLD_B = 4'd4;
   localparam logic [IDX_W-1:0] FLD_C = 4'd6;
   localparam logic [IDX_W-1:0] FLD_D = 4'd11;

   localparam logic [ACC_W-1:0] LOAD_OVER = ACC_W'(2);

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_SIGN,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   typedef struct packed {
      phase_type         phase;
      logic              neg;
      logic [ACC_W-1:0]  acc;
   } num_state_type;

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic [IDX_W-1:0]        field_index;
      logic signed [ACC_W-1:0] value_hundredths;
      logic signed [ERR_W-1:0] error_code;
      logic                    solar_charge;
      logic                    inverter_on;
      logic [BAT_W-1:0]        battery_state;
      logic                    overload;
      logic                    charging;
   } result_type;

   function automatic logic is_div100(input logic [IDX_W-1:0] f);
      logic r;
      r = (f == FLD_A) || (f == FLD_B) || (f == FLD_C) || (f == FLD_D);
      return r;
   endfunction

endpackage
`default_nettype wire

/* src/ufp_intf.sv */
// channel interfaces: received bytes, results and the header register write
`default_nettype none
interface ufp_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface ufp_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [ufp_pkg::KIND_W-1:0]             kind;
   logic [ufp_pkg::IDX_W-1:0]              field_index;
   logic signed [ufp_pkg::ACC_W-1:0]       value_hundredths;
   logic signed [ufp_pkg::ERR_W-1:0]       error_code;
   logic                                   solar_charge;
   logic                                   inverter_on;
   logic [ufp_pkg::BAT_W-1:0]              battery_state;
   logic                                   overload;
   logic                                   charging;
   modport source (output valid, output kind, output field_index, output value_hundredths,
                   output error_code, output solar_charge, output inverter_on,
                   output battery_state, output overload, output charging, input ready);
   modport sink (input valid, input kind, input field_index, input value_hundredths,
                 input error_code, input solar_charge, input inverter_on,
                 input battery_state, input overload, input charging, output ready);
endinterface

interface ufp_csr_if;
   logic                        valid;
   logic                        ready;
   logic [ufp_pkg::HDR_W-1:0]   data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/ufp_num_step.sv */
// one byte step of the atoi style decimal parser
`default_nettype none
module ufp_num_step (
   input  wire ufp_pkg::num_state_type             cur,
   input  wire logic [7:0]                          char_in,
   output ufp_pkg::num_state_type                   nxt,
   output logic signed [ufp_pkg::ACC_W-1:0]         value
);
   import ufp_pkg::*;

   logic is_digit;
   logic is_space;
   logic is_sign;

   assign is_digit = (char_in >= CH_0) && (char_in <= CH_9);
   assign is_space = (char_in == CH_SP) || ((char_in >= CH_TAB) && (char_in <= CH_CR));
   assign is_sign  = (char_in == CH_PLUS) || (char_in == CH_MINUS);

   always_comb begin
      nxt = cur;
      if (cur.phase == PH_LEAD && is_space) begin
         nxt = cur;
      end else if (cur.phase == PH_LEAD && is_sign) begin
         nxt.neg   = (char_in == CH_MINUS);
         nxt.phase = PH_SIGN;
      end else if (cur.phase != PH_DONE) begin
         if (is_digit) begin
            // acc * 10 + digit, wrapping at the accumulator width
            nxt.acc   = (cur.acc << 3) + (cur.acc << 1)
                        + {{(ACC_W-4){1'b0}}, char_in[3:0]};
            nxt.phase = PH_DIGITS;
         end else begin
            nxt.phase = PH_DONE;
         end
      end
   end

   assign value = nxt.neg ? -$signed(nxt.acc) : $signed(nxt.acc);

endmodule
`default_nettype wire

/* src/ufp_rsp_buf.sv */
// two-slot output register with skid slot for the result channel
`default_nettype none
module ufp_rsp_buf (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire ufp_pkg::result_type     push_data,
   output logic                         full,
   ufp_rsp_if.source                    rsp_ch
);
   import ufp_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop  = main_valid_ff && rsp_ch.ready;
   assign full = skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid            = main_valid_ff;
   assign rsp_ch.kind             = main_ff.kind;
   assign rsp_ch.field_index      = main_ff.field_index;
   assign rsp_ch.value_hundredths = main_ff.value_hundredths;
   assign rsp_ch.error_code       = main_ff.error_code;
   assign rsp_ch.solar_charge     = main_ff.solar_charge;
   assign rsp_ch.inverter_on      = main_ff.inverter_on;
   assign rsp_ch.battery_state    = main_ff.battery_state;
   assign rsp_ch.overload         = main_ff.overload;
   assign rsp_ch.charging         = main_ff.charging;

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid slot holds a result while the output slot is empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_ch.ready) |=> skid_valid_ff && $stable(skid_ff))
      else $error("stalled skid result was overwritten");

endmodule
`default_nettype wire

/* src/ups_telemetry_frame_parser.sv */
// a completed result is registered in the output register, or the skid slot if held
// throughput: one byte per cycle while req_ch.ready; frame state updated in one pass
// req_ch.ready drops only while both output slots (output register and skid) are full
// reset (synchronous): back to line-feed hunt, parser and saved status cleared,
// header register set to "AD00"; csr_ch writes are always taken
`default_nettype none
module ups_telemetry_frame_parser (
   input  wire logic   clock,
   input  wire logic   reset,
   ufp_byte_if.sink    req_ch,
   ufp_rsp_if.source   rsp_ch,
   ufp_csr_if.sink     csr_ch
);
   import ufp_pkg::*;

   typedef enum logic [1:0] {
      HUNT_LF,
      WAIT_CR,
      IN_FRAME,
      SKIP_FRAME
   } mode_type;

   mode_type            mode_ff, mode_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [IDX_W-1:0]    field_ff, field_in;
   num_state_type       num_ff, num_in;
   logic [ERR_W-1:0]    err_ff, err_in;
   logic                solar_ff, solar_in;
   logic                inv_ff, inv_in;
   logic                over_ff, over_in;
   logic [BAT_W-1:0]    bat_ff, bat_in;
   logic [HDR_W-1:0]    header_ff;

   logic                accept;
   logic                buf_full;
   logic                produced;
   result_type          res;
   logic [7:0]          c;
   logic [7:0]          want;
   logic                mism;
   logic                field_last;
   logic                restart_num;
   num_state_type       step_cur;
   num_state_type       step_nxt;
   logic signed [ACC_W-1:0] step_value;
   logic signed [ACC_W-1:0] scaled;

   assign c             = req_ch.rx_byte;
   assign req_ch.ready  = !buf_full;
   assign accept        = req_ch.valid && req_ch.ready;
   assign csr_ch.ready  = 1'b1;

   // status numbers start fresh at their first byte
   assign restart_num = (pos_ff == POS_ERR) || (pos_ff == POS_LOAD);
   assign step_cur    = restart_num ? '0 : num_ff;

   ufp_num_step u_num_step (
      .cur     (step_cur),
      .char_in (c),
      .nxt     (step_nxt),
      .value   (step_value)
   );

   always_comb begin
      case (pos_ff[1:0])
         2'd0:    want = header_ff[31:24];
         2'd1:    want = header_ff[23:16];
         2'd2:    want = header_ff[15:8];
         default: want = header_ff[7:0];
      endcase
   end

   assign mism       = (want != c);
   assign field_last = (pos_ff < POS_SHORT_END) ? (pos_ff[1:0] == 2'b11)
                                                : (pos_ff == POS_FIELDS_LAST);
   assign scaled     = is_div100(field_ff) ? step_value
                                           : (step_value <<< 3) + (step_value <<< 1);

   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      field_in = field_ff;
      num_in   = num_ff;
      err_in   = err_ff;
      solar_in = solar_ff;
      inv_in   = inv_ff;
      over_in  = over_ff;
      bat_in   = bat_ff;
      produced = 1'b0;
      res      = '0;
      case (mode_ff)
         HUNT_LF: begin
            if (c == CH_LF) mode_in = WAIT_CR;
         end
         WAIT_CR: begin
            if (c == CH_CR) begin
               mode_in  = IN_FRAME;
               pos_in   = '0;
               field_in = '0;
               num_in   = '0;
            end else begin
               mode_in = HUNT_LF;
            end
         end
         IN_FRAME, SKIP_FRAME: begin
            if (pos_ff < POS_HDR_END) begin
               if (mism) mode_in = SKIP_FRAME;
               if (pos_ff == POS_HDR_LAST && (mism || mode_ff == SKIP_FRAME)) begin
                  produced = 1'b1;
                  res.kind = KIND_HDR;
               end
            end else if (mode_ff == IN_FRAME) begin
               if (pos_ff <= POS_FIELDS_LAST) begin
                  num_in = step_nxt;
                  if (field_last) begin
                     produced             = 1'b1;
                     res.kind             = KIND_FIELD;
                     res.field_index      = field_ff;
                     res.value_hundredths = scaled;
                     field_in             = field_ff + 1'b1;
                     num_in               = '0;
                  end
               end else if (pos_ff == POS_ERR) begin
                  num_in = step_nxt;
               end else if (pos_ff == POS_ERR_LAST) begin
                  err_in = step_value[ERR_W-1:0];
                  num_in = '0;
               end else if (pos_ff == POS_SOLAR) begin
                  solar_in = (c != CH_0);
               end else if (pos_ff == POS_INV) begin
                  inv_in = (c != CH_0);
               end else if (pos_ff == POS_BAT) begin
                  bat_in = (c == CH_0) ? BAT_NORMAL : ((c == CH_1) ? BAT_LOW_TRIP : BAT_LOW);
               end else if (pos_ff == POS_LOAD) begin
                  num_in = step_nxt;
               end else if (pos_ff == POS_LOAD_LAST) begin
                  over_in = !step_nxt.neg && (step_nxt.acc == LOAD_OVER);
                  num_in  = '0;
               end else if (pos_ff == POS_CHG) begin
                  produced          = 1'b1;
                  res.kind          = KIND_STATUS;
                  res.error_code    = err_ff;
                  res.solar_charge  = solar_ff;
                  res.inverter_on   = inv_ff;
                  res.battery_state = bat_ff;
                  res.overload      = over_ff;
                  res.charging      = (c != CH_0);
               end
            end
            if (pos_ff == POS_CHG) begin
               mode_in  = HUNT_LF;
               pos_in   = '0;
               field_in = '0;
               num_in   = '0;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         default: mode_in = HUNT_LF;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= HUNT_LF;
         pos_ff    <= '0;
         field_ff  <= '0;
         num_ff    <= '0;
         err_ff    <= '0;
         solar_ff  <= 1'b0;
         inv_ff    <= 1'b0;
         over_ff   <= 1'b0;
         bat_ff    <= '0;
         header_ff <= HEADER_RESET;
      end else begin
         if (accept) begin
            mode_ff  <= mode_in;
            pos_ff   <= pos_in;
            field_ff <= field_in;
            num_ff   <= num_in;
            err_ff   <= err_in;
            solar_ff <= solar_in;
            inv_ff   <= inv_in;
            over_ff  <= over_in;
            bat_ff   <= bat_in;
         end
         if (csr_ch.valid && csr_ch.ready) begin
            header_ff <= csr_ch.data;
         end
      end
   end

   ufp_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && produced),
      .push_data (res),
      .full      (buf_full),
      .rsp_ch    (rsp_ch)
   );

   a_hunt_pos_zero: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == HUNT_LF || mode_ff == WAIT_CR) |-> pos_ff == '0)
      else $error("frame position not cleared outside a frame");

   a_hdr_result_pos: assert property (@(posedge clock) disable iff (reset)
      (accept && produced && res.kind == KIND_HDR) |-> pos_ff == POS_HDR_LAST)
      else $error("header mismatch reported off the last header byte");

   a_field_in_frame: assert property (@(posedge clock) disable iff (reset)
      (accept && produced && res.kind == KIND_FIELD)
         |-> mode_ff == IN_FRAME && pos_ff <= POS_FIELDS_LAST)
      else $error("measurement field reported outside the field area");

   a_skip_no_fields: assert property (@(posedge clock) disable iff (reset)
      (accept && mode_ff == SKIP_FRAME && pos_ff > POS_HDR_LAST) |-> !produced)
      else $error("result emitted from a rejected frame body");

endmodule
`default_nettype wire

/* verif/tb.sv */
// self-checking testbench for the telemetry frame parser: framed byte traffic vs a local predictor
`timescale 1ns / 1ps
module tb;
   import ufp_pkg::*;

   localparam int  RESET_CYCLES      = 5;
   localparam int  IDLE_PCT          = 21;
   localparam int  SETTLE_CYCLES     = 4;
   localparam int  PHASE_FRAME_BYTES = 130;
   localparam int  CYCLE_LIMIT       = 200000;
   localparam logic [7:0] CH_NUL     = 8'h00;

   typedef enum logic [1:0] {
      HUNT_LF,
      WAIT_CR,
      IN_FRAME,
      SKIP_FRAME
   } link_state_type;

   logic clock = 1'b0;
   logic reset;

   ufp_byte_if req_if ();
   ufp_rsp_if  rsp_if ();
   ufp_csr_if  csr_if ();

   ups_telemetry_frame_parser uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // stimulus and expectations
   logic [7:0]  rx_stream [$];
   result_type  pending_results [$];
   logic [31:0] frame_hdr;
   logic        steady;
   logic        rx_taken;
   int          cycle_count;
   int          bytes_taken;
   int          frames_queued;
   int          results_seen;
   int          mismatches;
   int          kind_count [3];

   // predictor state
   link_state_type link_st;
   logic [5:0]     frame_pos;
   logic [3:0]     field_num;
   phase_type      num_phase;
   logic           num_neg;
   logic [27:0]    num_acc;
   logic [31:0]    hdr_cfg;
   logic [7:0]     err_save;
   logic           solar_save;
   logic           inv_save;
   logic           over_save;
   logic [1:0]     bat_save;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
   endtask

   task automatic num_clear();
      num_phase = PH_LEAD;
      num_neg   = 1'b0;
      num_acc   = '0;
   endtask

   // atoi-style digit accumulation, one character at a time
   task automatic num_take(input logic [7:0] c);
      if (num_phase == PH_LEAD && (c == CH_SP || (c >= CH_TAB && c <= CH_CR))) begin
      end else if (num_phase == PH_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
         num_neg   = (c == CH_MINUS);
         num_phase = PH_SIGN;
      end else if (num_phase != PH_DONE) begin
         if (c >= CH_0 && c <= CH_9) begin
            num_acc   = num_acc * 28'd10 + 28'(c - CH_0);
            num_phase = PH_DIGITS;
         end else begin
            num_phase = PH_DONE;
         end
      end
   endtask

   function automatic longint num_value();
      longint v;
      v = longint'({36'd0, num_acc});
      return num_neg ? -v : v;
   endfunction

   task automatic predictor_reset();
      link_st    = HUNT_LF;
      frame_pos  = '0;
      field_num  = '0;
      num_clear();
      hdr_cfg    = HEADER_RESET;
      err_save   = '0;
      solar_save = 1'b0;
      inv_save   = 1'b0;
      over_save  = 1'b0;
      bat_save   = BAT_NORMAL;
   endtask

   task automatic predict_byte(input logic [7:0] c);
      logic [5:0]  p;
      logic [7:0]  want;
      longint      v;
      result_type  r;
      logic        last;
      logic        scaled;
      p = frame_pos;
      r = '0;
      case (link_st)
         HUNT_LF: begin
            if (c == CH_LF) link_st = WAIT_CR;
         end
         WAIT_CR: begin
            if (c == CH_CR) begin
               link_st   = IN_FRAME;
               frame_pos = '0;
               field_num = '0;
               num_clear();
            end else begin
               link_st = HUNT_LF;
            end
         end
         default: begin
            if (p < POS_HDR_END) begin
               want = hdr_cfg[8 * (3 - int'(p)) +: 8];
               if (want != c) link_st = SKIP_FRAME;
               // one error per rejected frame, reported on the last header byte
               if (p == POS_HDR_LAST && link_st == SKIP_FRAME) begin
                  r.kind = KIND_HDR;
                  pending_results.push_back(r);
               end
            end else if (link_st == IN_FRAME) begin
               if (p < POS_ERR) begin
                  num_take(c);
                  last = (p < POS_SHORT_END) ? (p[1:0] == 2'd3) : (p == POS_FIELDS_LAST);
                  if (last) begin
                     case (field_num)
                        FLD_A, FLD_B, FLD_C, FLD_D: scaled = 1'b0;
                        default: scaled = 1'b1;
                     endcase
                     v = num_value();
                     if (scaled) v = v * 10;
                     r.kind             = KIND_FIELD;
                     r.field_index      = field_num;
                     r.value_hundredths = v[27:0];
                     pending_results.push_back(r);
                     field_num = field_num + 4'd1;
                     num_clear();
                  end
               end else if (p == POS_ERR || p == POS_ERR_LAST) begin
                  if (p == POS_ERR) num_clear();
                  num_take(c);
                  if (p == POS_ERR_LAST) begin
                     v        = num_value();
                     err_save = v[7:0];
                     num_clear();
                  end
               end else if (p == POS_SOLAR) begin
                  solar_save = (c != CH_0);
               end else if (p == POS_INV) begin
                  inv_save = (c != CH_0);
               end else if (p == POS_BAT) begin
                  bat_save = (c == CH_0) ? BAT_NORMAL : (c == CH_1) ? BAT_LOW_TRIP : BAT_LOW;
               end else if (p == POS_LOAD || p == POS_LOAD_LAST) begin
                  if (p == POS_LOAD) num_clear();
                  num_take(c);
                  if (p == POS_LOAD_LAST) begin
                     over_save = (num_value() == longint'(LOAD_OVER));
                     num_clear();
                  end
               end else if (p == POS_CHG) begin
                  r.kind          = KIND_STATUS;
                  r.error_code    = err_save;
                  r.solar_charge  = solar_save;
                  r.inverter_on   = inv_save;
                  r.battery_state = bat_save;
                  r.overload      = over_save;
                  r.charging      = (c != CH_0);
                  pending_results.push_back(r);
               end
            end
            if (p == POS_CHG) begin
               link_st   = HUNT_LF;
               frame_pos = '0;
               field_num = '0;
               num_clear();
            end else begin
               frame_pos = p + 6'd1;
            end
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic signed [31:0] got,
                              input logic signed [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                   results_seen, name, got, want));
   endtask

   task automatic check_result();
      result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch($sformatf("result of kind %0d arrived with nothing expected",
                                   rsp_if.kind));
      end else begin
         want = pending_results.pop_front();
         check_field("kind", rsp_if.kind, want.kind);
         check_field("field_index", rsp_if.field_index, want.field_index);
         check_field("value_hundredths", rsp_if.value_hundredths, want.value_hundredths);
         check_field("error_code", rsp_if.error_code, want.error_code);
         check_field("solar_charge", rsp_if.solar_charge, want.solar_charge);
         check_field("inverter_on", rsp_if.inverter_on, want.inverter_on);
         check_field("battery_state", rsp_if.battery_state, want.battery_state);
         check_field("overload", rsp_if.overload, want.overload);
         check_field("charging", rsp_if.charging, want.charging);
         if (want.kind <= KIND_HDR) kind_count[want.kind]++;
         results_seen++;
      end
   endtask

   // monitor: every transaction is sampled at the rising edge
   always @(posedge clock) begin
      cycle_count++;
      rx_taken = req_if.valid && req_if.ready;
      if (reset) begin
         predictor_reset();
      end else begin
         if (csr_if.valid && csr_if.ready) hdr_cfg = csr_if.data;
         if (rx_taken) begin
            predict_byte(req_if.rx_byte);
            bytes_taken++;
         end
         if (rsp_if.valid && rsp_if.ready) check_result();
      end
   end

   // driver: byte stream and result back-pressure change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         rsp_if.ready <= 1'b0;
      end else begin
         if (!req_if.valid || rx_taken) begin
            if (rx_stream.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               req_if.valid   <= 1'b1;
               req_if.rx_byte <= rx_stream.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
         rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   function automatic logic [7:0] status_char();
      case ($urandom_range(3))
         0: return CH_0;
         1: return CH_1;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic queue_text(input string s);
      int k;
      for (k = 0; k < s.len(); k++) rx_stream.push_back(s[k]);
   endtask

   // one fixed-width ascii number in one of several shapes
   task automatic queue_number(input int width);
      logic [7:0] txt [8];
      int nd, lead, k;
      nd   = $urandom_range(width, 1);
      lead = width - nd;
      for (k = 0; k < 8; k++) txt[k] = CH_0 + 8'($urandom_range(9));
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            for (k = 0; k < lead; k++) txt[k] = CH_SP;
            if (lead > 0 && $urandom_range(1))
               txt[lead - 1] = $urandom_range(1) ? CH_MINUS : CH_PLUS;
         end
         4: for (k = nd; k < width; k++) txt[k] = 8'($urandom);
         5: for (k = 0; k < lead; k++)
               txt[k] = $urandom_range(5) ? CH_TAB + 8'($urandom_range(4)) : CH_SP;
         6: for (k = 0; k < width; k++) txt[k] = CH_SP;
         7: begin
            // sign followed by a sign or digits
            txt[0] = $urandom_range(1) ? CH_MINUS : CH_PLUS;
            if ($urandom_range(1)) txt[1] = $urandom_range(1) ? CH_MINUS : CH_PLUS;
         end
         8: for (k = 0; k < width; k++) txt[k] = 8'($urandom);
         default: begin
            for (k = 0; k < width; k++) txt[k] = CH_9;
            if ($urandom_range(1)) txt[0] = CH_MINUS;
            else if ($urandom_range(1)) txt[$urandom_range(width - 1)] = CH_NUL;
         end
      endcase
      for (k = 0; k < width; k++) rx_stream.push_back(txt[k]);
   endtask

   task automatic queue_body();
      int k;
      for (k = 0; k < 11; k++) queue_number(4);
      queue_number(8);
      queue_number(2);
      for (k = 0; k < 3; k++) rx_stream.push_back(status_char());
      // overload field is most interesting near the value 2
      if ($urandom_range(1)) begin
         rx_stream.push_back($urandom_range(1) ? CH_SP : CH_0);
         rx_stream.push_back(CH_0 + 8'd2);
      end else begin
         queue_number(2);
      end
      rx_stream.push_back(status_char());
   endtask

   task automatic queue_frame(input logic [31:0] hdr, input logic spoil);
      logic [31:0] h;
      int k, slot;
      h = hdr;
      if (spoil) begin
         slot = $urandom_range(3);
         h[8 * slot +: 8] = h[8 * slot +: 8] ^ 8'($urandom_range(255, 1));
      end
      rx_stream.push_back(CH_LF);
      rx_stream.push_back(CH_CR);
      for (k = 3; k >= 0; k--) rx_stream.push_back(h[8 * k +: 8]);
      queue_body();
      frames_queued++;
   endtask

   // mostly well-formed frames, with rejected headers, noise and broken sync mixed in
   task automatic queue_traffic(input logic [31:0] hdr);
      int frame_bytes, pick;
      frame_bytes = 0;
      while (frame_bytes < PHASE_FRAME_BYTES) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            queue_frame(hdr, pick >= 70);
            frame_bytes += FRAME_BYTES + 2;
         end else if (pick < 90) begin
            repeat ($urandom_range(12, 1)) rx_stream.push_back(8'($urandom));
         end else begin
            rx_stream.push_back(CH_LF);
            rx_stream.push_back($urandom_range(1) ? CH_LF : 8'($urandom));
         end
      end
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (rx_stream.size() != 0 || req_if.valid || pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_header(input logic [31:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b0;
      frame_hdr = value;
   endtask

   initial begin
      reset          = 1'b1;
      steady         = 1'b0;
      rx_taken       = 1'b0;
      req_if.valid   = 1'b0;
      req_if.rx_byte = '0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.data    = '0;
      frame_hdr      = HEADER_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sync corners: second line feed dropped, stray carriage return, extreme bytes
      queue_text("\n\n\r\nx\r");
      rx_stream.push_back(CH_NUL);
      rx_stream.push_back(8'hFF);

      // hand-built frame: full-scale, signed, empty and malformed fields
      queue_text("\n\rAD00");
      queue_text("9999-999   0 \t+7+-1212x4    \r\n-50000-0 9");
      queue_text("7");
      rx_stream.push_back(CH_NUL);
      queue_text("12");
      queue_text("99999999");
      queue_text("-910  2");
      queue_text("1");
      frames_queued++;

      // header mismatch on the last header byte only, zero byte against '0'
      queue_text("\n\rAD0");
      rx_stream.push_back(CH_NUL);
      queue_body();
      frames_queued++;

      queue_traffic(frame_hdr);
      wait_drained();

      steady = 1'b1;
      write_header($urandom);
      queue_traffic(frame_hdr);
      wait_drained();
      steady = 1'b0;

      write_header(32'h0000_0000);
      queue_traffic(frame_hdr);
      wait_drained();

      write_header(32'hFFFF_FFFF);
      queue_traffic(frame_hdr);
      wait_drained();

      $display("sent %0d bytes in %0d framed sequences plus noise; checked %0d results",
               bytes_taken, frames_queued, results_seen);
      $display("fields %0d, status %0d, header errors %0d; headers: reset, random, zeros, ones",
               kind_count[KIND_FIELD], kind_count[KIND_STATUS], kind_count[KIND_HDR]);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
